/* hw/rtl/lrr_pkg.sv */
// Package for the laser scanner response receiver: protocol constants, result kinds,
// the result word type and the descriptor and command tables.
// Depends on nothing; used by lidar_response_receiver and its testbench.
`timescale 1ns / 1ps

package lrr_pkg;

   // Request kinds as carried on the request channel.
   localparam logic [2:0] REQ_SCAN       = 3'd0;
   localparam logic [2:0] REQ_FORCE_SCAN = 3'd1;
   localparam logic [2:0] REQ_INFO       = 3'd2;
   localparam logic [2:0] REQ_HEALTH     = 3'd3;
   localparam logic [2:0] REQ_RESET      = 3'd4;
   localparam logic [2:0] REQ_NONE       = 3'd5;

   localparam logic [7:0] SYNC_BYTE = 8'hA5;
   localparam logic [2:0] DESC_LAST = 3'd6;

   // Depth of the result queue; the request side needs room for two results.
   localparam int RSP_DEPTH = 4;
   localparam int PTR_W     = $clog2(RSP_DEPTH);
   localparam int CNT_W     = $clog2(RSP_DEPTH + 1);

   typedef enum logic [2:0] {
      KIND_TX         = 3'd0,
      KIND_DESC_MATCH = 3'd1,
      KIND_DESC_DONE  = 3'd2,
      KIND_MISMATCH   = 3'd3,
      KIND_PAYLOAD    = 3'd4,
      KIND_PACKET     = 3'd5,
      KIND_IGNORED    = 3'd6
   } kind_type;

   typedef struct packed {
      logic [31:0] scan_count;
      logic [39:0] scan_word;
      logic [7:0]  data_byte;
      logic [4:0]  byte_index;
      logic [2:0]  packet_kind;
      logic [7:0]  tx_byte;
      kind_type    kind;
      logic        last;
   } rsp_entry_type;

   function automatic logic [7:0] cmd_byte(input logic [2:0] req);
      logic [7:0] b;
      case (req)
         REQ_SCAN:       b = 8'h20;
         REQ_FORCE_SCAN: b = 8'h21;
         REQ_INFO:       b = 8'h50;
         REQ_HEALTH:     b = 8'h52;
         REQ_RESET:      b = 8'h40;
         default:        b = 8'h00;
      endcase
      return b;
   endfunction

   // Expected response descriptor byte for a request that has a response.
   function automatic logic [7:0] descr_byte(input logic [1:0] req, input logic [2:0] pos);
      logic [7:0] b;
      case (pos)
         3'd0:    b = 8'hA5;
         3'd1:    b = 8'h5A;
         3'd2: begin
            case (req)
               2'd2:    b = 8'h14;
               2'd3:    b = 8'h03;
               default: b = 8'h05;
            endcase
         end
         3'd5:    b = (req[1]) ? 8'h00 : 8'h40;
         3'd6: begin
            case (req)
               2'd2:    b = 8'h04;
               2'd3:    b = 8'h06;
               default: b = 8'h81;
            endcase
         end
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [4:0] payload_len(input logic [1:0] req);
      logic [4:0] n;
      case (req)
         2'd2:    n = 5'd20;
         2'd3:    n = 5'd3;
         default: n = 5'd5;
      endcase
      return n;
   endfunction

endpackage

/* hw/rtl/lidar_response_receiver.sv */
// Laser scanner serial response receiver: request encoder, descriptor matcher,
// payload packetizer and result queue. Depends on lrr_pkg.
`timescale 1ns / 1ps

// Each request word either asks for a command to be sent (tuser low: two result words,
// the sync byte and the command byte; one ignored word for an unknown kind) or carries one
// byte received from the scanner (tuser high). Received bytes are matched against the
// seven-byte response descriptor of the last request, then grouped into payload packets;
// the last byte of a packet gives a payload word followed by a packet-complete word. A
// request word is processed in the cycle it is accepted and its results go into a four-word
// result queue, so one request word is taken every cycle as long as the queue has room for
// two results; the sustained rate is set by the result side, one result word per cycle.
module lidar_response_receiver (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // request_kind[2:0], rx_byte[10:3], zeros above
   input  logic         req_tuser,   // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // tx_byte[7:0], packet_kind[10:8], byte_index[15:11],
                                     // data_byte[23:16], scan_word[63:24], scan_count[95:64]
   output logic [2:0]   rsp_tuser,   // kind
   output logic         rsp_tlast
);
   import lrr_pkg::*;

   logic [2:0]  active_ff, active_in;
   logic        done_ff, done_in;
   logic [4:0]  pos_ff, pos_in;
   logic [39:0] build_ff, build_in;
   logic [39:0] latched_ff, latched_in;
   logic [31:0] total_ff, total_in;

   rsp_entry_type fifo_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic          req_accept, rsp_pop, two;
   logic [2:0]    req_kind;
   logic [7:0]    rx_byte;
   logic [2:0]    dpos;
   logic [4:0]    plen, ppos;
   logic          is_scan;
   logic [1:0]    push_num;
   rsp_entry_type r0, r1, head;

   assign req_kind   = req_tdata[2:0];
   assign rx_byte    = req_tdata[10:3];
   assign req_tready = (count_ff <= CNT_W'(RSP_DEPTH - 2));
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_pop    = rsp_tvalid && rsp_tready;

   always_comb begin
      active_in  = active_ff;
      done_in    = done_ff;
      pos_in     = pos_ff;
      build_in   = build_ff;
      latched_in = latched_ff;
      total_in   = total_ff;
      r0         = '0;
      r1         = '0;
      two        = 1'b0;
      dpos       = (pos_ff >= 5'd7) ? 3'd0 : pos_ff[2:0];
      plen       = payload_len(active_ff[1:0]);
      ppos       = (pos_ff >= plen) ? 5'd0 : pos_ff;
      is_scan    = (active_ff <= REQ_FORCE_SCAN);
      if (req_accept) begin
         if (!req_tuser) begin
            if (req_kind > REQ_RESET) begin
               r0.kind = KIND_IGNORED;
               r0.last = 1'b1;
            end else begin
               active_in      = req_kind;
               done_in        = 1'b0;
               pos_in         = '0;
               r0.kind        = KIND_TX;
               r0.tx_byte     = SYNC_BYTE;
               r0.packet_kind = req_kind;
               r1.kind        = KIND_TX;
               r1.tx_byte     = cmd_byte(req_kind);
               r1.packet_kind = req_kind;
               r1.last        = 1'b1;
               two            = 1'b1;
            end
         end else if (active_ff > REQ_HEALTH) begin
            // No response is expected after a reset request or before any request.
            r0.kind      = KIND_IGNORED;
            r0.data_byte = rx_byte;
            r0.last      = 1'b1;
         end else if (!done_ff) begin
            r0.packet_kind = active_ff;
            r0.byte_index  = {2'b00, dpos};
            r0.data_byte   = rx_byte;
            r0.last        = 1'b1;
            pos_in         = {2'b00, dpos};
            if (rx_byte != descr_byte(active_ff[1:0], dpos)) begin
               r0.kind = KIND_MISMATCH;
            end else if (dpos == DESC_LAST) begin
               done_in = 1'b1;
               pos_in  = '0;
               r0.kind = KIND_DESC_DONE;
            end else begin
               pos_in  = {2'b00, dpos + 3'd1};
               r0.kind = KIND_DESC_MATCH;
            end
         end else begin
            if (is_scan) begin
               case (ppos[2:0])
                  3'd0:    build_in[7:0]   = rx_byte;
                  3'd1:    build_in[15:8]  = rx_byte;
                  3'd2:    build_in[23:16] = rx_byte;
                  3'd3:    build_in[31:24] = rx_byte;
                  3'd4:    build_in[39:32] = rx_byte;
                  default: build_in        = build_ff;
               endcase
            end
            r0.kind        = KIND_PAYLOAD;
            r0.packet_kind = active_ff;
            r0.byte_index  = ppos;
            r0.data_byte   = rx_byte;
            if (ppos == plen - 5'd1) begin
               pos_in = '0;
               if (is_scan) begin
                  latched_in = build_in;
                  total_in   = total_ff + 32'd1;
               end
               r1.kind        = KIND_PACKET;
               r1.packet_kind = active_ff;
               r1.byte_index  = ppos;
               r1.data_byte   = rx_byte;
               r1.last        = 1'b1;
               two            = 1'b1;
            end else begin
               pos_in  = ppos + 5'd1;
               r0.last = 1'b1;
            end
         end
      end
      r0.scan_word  = latched_in;
      r0.scan_count = total_in;
      r1.scan_word  = latched_in;
      r1.scan_count = total_in;
   end

   assign push_num  = req_accept ? {two, ~two} : 2'd0;
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_num);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(rsp_pop);
   assign count_in  = count_ff + CNT_W'(push_num) - CNT_W'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= REQ_NONE;
         done_ff    <= 1'b0;
         pos_ff     <= '0;
         build_ff   <= '0;
         latched_ff <= '0;
         total_ff   <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         active_ff  <= active_in;
         done_ff    <= done_in;
         pos_ff     <= pos_in;
         build_ff   <= build_in;
         latched_ff <= latched_in;
         total_ff   <= total_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
      end
   end

   // The result queue holds payload only and needs no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         fifo_ff[wr_ptr_ff] <= r0;
         if (two) begin
            fifo_ff[wr_ptr_ff + PTR_W'(1)] <= r1;
         end
      end
   end

   assign head      = fifo_ff[rd_ptr_ff];
   assign rsp_tdata = {head.scan_count, head.scan_word, head.data_byte,
                       head.byte_index, head.packet_kind, head.tx_byte};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RSP_DEPTH))
      else $error("result queue count beyond depth");

   a_idle_state: assert property (@(posedge clock) disable iff (reset)
      (active_ff > REQ_HEALTH) |-> (!done_ff && pos_ff == 5'd0))
      else $error("match state not clear without an active request");

   a_desc_pos: assert property (@(posedge clock) disable iff (reset)
      !done_ff |-> (pos_ff < 5'd7))
      else $error("descriptor position out of range");

   a_count_scan_only: assert property (@(posedge clock) disable iff (reset)
      (total_ff != $past(total_ff)) |-> ($past(active_ff) <= REQ_FORCE_SCAN && $past(done_ff)))
      else $error("scan count moved outside a scan payload");

   a_full_no_accept: assert property (@(posedge clock) disable iff (reset)
      (count_ff > CNT_W'(RSP_DEPTH - 2)) |=> (count_ff <= $past(count_ff)))
      else $error("result queue grew while nearly full");

endmodule

/* bench/tb_lidar_response_receiver.sv */
// Self-checking testbench for lidar_response_receiver: directed table, then random
// request sessions, checked word by word against a predictor of the receiver.
// Depends on lrr_pkg and the lidar_response_receiver RTL.
`timescale 1ns / 1ps

module tb_lidar_response_receiver;
   import lrr_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 500;

   // Response descriptors, first byte in the low bits.
   localparam logic [55:0] DESC_SCAN   = 56'h81_40_00_00_05_5A_A5;
   localparam logic [55:0] DESC_INFO   = 56'h04_00_00_00_14_5A_A5;
   localparam logic [55:0] DESC_HEALTH = 56'h06_00_00_00_03_5A_A5;

   typedef struct {
      logic          act;
      logic [2:0]    rk;
      logic [7:0]    rb;
      int            n_typed;
      rsp_entry_type t0;
      rsp_entry_type t1;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [15:0]  req_tdata;   // request_kind[2:0], rx_byte[10:3], zeros above
   logic         req_tuser;   // action
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;   // tx_byte[7:0], packet_kind[10:8], byte_index[15:11],
                              // data_byte[23:16], scan_word[63:24], scan_count[95:64]
   logic [2:0]   rsp_tuser;   // kind
   logic         rsp_tlast;

   // Predicted receiver state.
   logic [2:0]   p_active;
   logic         p_desc_done;
   logic [4:0]   p_pos;
   logic [39:0]  p_build;
   logic [39:0]  p_latched;
   logic [31:0]  p_total;

   rsp_entry_type awaited_rsp[$];
   stim_row_type  stim_table[$];
   rsp_entry_type exp_w, pr0, pr1;
   int            pn;
   int            err_count = 0;
   int            idle_cycles = 0;
   bit            calm = 1'b0;

   // Hand-typed expectations for the word currently offered, if any.
   int            cur_typed_n = 0;
   rsp_entry_type cur_t0, cur_t1;

   lidar_response_receiver i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] desc_at(input logic [2:0] rq, input logic [2:0] pos);
      logic [55:0] d;
      case (rq)
         REQ_INFO:   d = DESC_INFO;
         REQ_HEALTH: d = DESC_HEALTH;
         default:    d = DESC_SCAN;
      endcase
      return d[pos*8 +: 8];
   endfunction

   function automatic logic [7:0] tx_command(input logic [2:0] rq);
      logic [7:0] c;
      case (rq)
         REQ_SCAN:       c = 8'h20;
         REQ_FORCE_SCAN: c = 8'h21;
         REQ_INFO:       c = 8'h50;
         REQ_HEALTH:     c = 8'h52;
         default:        c = 8'h40;
      endcase
      return c;
   endfunction

   function automatic int payload_size(input logic [2:0] rq);
      int n;
      case (rq)
         REQ_INFO:   n = 20;
         REQ_HEALTH: n = 3;
         default:    n = 5;
      endcase
      return n;
   endfunction

   function automatic rsp_entry_type mk_rsp(input kind_type k, input logic [7:0] tx,
         input logic [2:0] pk, input logic [4:0] idx, input logic [7:0] data,
         input logic [39:0] word, input logic [31:0] count, input logic lst);
      rsp_entry_type r;
      r.kind        = k;
      r.tx_byte     = tx;
      r.packet_kind = pk;
      r.byte_index  = idx;
      r.data_byte   = data;
      r.scan_word   = word;
      r.scan_count  = count;
      r.last        = lst;
      return r;
   endfunction

   // Advances the predicted state by one request word and returns its results.
   task automatic predict_response(input logic act, input logic [2:0] rk, input logic [7:0] rb,
         output rsp_entry_type r0, output rsp_entry_type r1, output int n);
      int len;
      r0 = '0;
      r1 = '0;
      n  = 1;
      if (!act) begin
         if (rk > REQ_RESET) begin
            r0.kind = KIND_IGNORED;
         end else begin
            p_active       = rk;
            p_desc_done    = 1'b0;
            p_pos          = '0;
            r0.kind        = KIND_TX;
            r0.tx_byte     = SYNC_BYTE;
            r0.packet_kind = rk;
            r1             = r0;
            r1.tx_byte     = tx_command(rk);
            n              = 2;
         end
      end else if (p_active > REQ_HEALTH) begin
         // No response is expected after a reset request or before any request.
         r0.kind      = KIND_IGNORED;
         r0.data_byte = rb;
      end else if (!p_desc_done) begin
         if (p_pos >= 7) p_pos = '0;
         r0.packet_kind = p_active;
         r0.byte_index  = p_pos;
         r0.data_byte   = rb;
         if (rb != desc_at(p_active, p_pos[2:0])) begin
            r0.kind = KIND_MISMATCH;
         end else if (p_pos == DESC_LAST) begin
            r0.kind     = KIND_DESC_DONE;
            p_desc_done = 1'b1;
            p_pos       = '0;
         end else begin
            r0.kind = KIND_DESC_MATCH;
            p_pos   = p_pos + 1'b1;
         end
      end else begin
         len = payload_size(p_active);
         if (p_pos >= len) p_pos = '0;
         r0.kind        = KIND_PAYLOAD;
         r0.packet_kind = p_active;
         r0.byte_index  = p_pos;
         r0.data_byte   = rb;
         if (p_active <= REQ_FORCE_SCAN) p_build[p_pos*8 +: 8] = rb;
         if (p_pos + 1 >= len) begin
            p_pos = '0;
            if (p_active <= REQ_FORCE_SCAN) begin
               p_latched = p_build;
               p_total   = p_total + 1'b1;
            end
            r1      = r0;
            r1.kind = KIND_PACKET;
            n       = 2;
         end else begin
            p_pos = p_pos + 1'b1;
         end
      end
      r0.scan_word  = p_latched;
      r0.scan_count = p_total;
      r0.last       = (n == 1);
      r1.scan_word  = p_latched;
      r1.scan_count = p_total;
      r1.last       = 1'b1;
   endtask

   task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
      if (e !== a) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
         err_count++;
      end
   endtask

   // Offers one request word, idling first at random, and returns after its acceptance.
   task automatic send_word(input logic act, input logic [2:0] rk, input logic [7:0] rb);
      while (!calm && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {5'b0, rb, rk};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Holds the request side until every awaited result has arrived.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (awaited_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic add_row(input logic act, input logic [2:0] rk, input logic [7:0] rb,
         input int n_typed, input rsp_entry_type t0, input rsp_entry_type t1);
      stim_row_type row;
      row.act     = act;
      row.rk      = rk;
      row.rb      = rb;
      row.n_typed = n_typed;
      row.t0      = t0;
      row.t1      = t1;
      stim_table.push_back(row);
   endtask

   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 21);
   end

   // Both handshakes are handled in one process so that prediction always
   // comes before the check of a result in the same cycle.
   always @(posedge clock) begin
      if (reset) begin
         p_active    = REQ_NONE;
         p_desc_done = 1'b0;
         p_pos       = '0;
         p_build     = '0;
         p_latched   = '0;
         p_total     = '0;
         awaited_rsp.delete();
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (req_tvalid && req_tready) begin
            predict_response(req_tuser, req_tdata[2:0], req_tdata[10:3], pr0, pr1, pn);
            if (cur_typed_n != 0) begin
               pn  = cur_typed_n;
               pr0 = cur_t0;
               pr1 = cur_t1;
            end
            awaited_rsp.push_back(pr0);
            if (pn == 2) awaited_rsp.push_back(pr1);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_rsp.size() == 0) begin
               $error("unexpected result word: kind 0x%0h", rsp_tuser);
               err_count++;
            end else begin
               exp_w = awaited_rsp.pop_front();
               check_field("kind", exp_w.kind, rsp_tuser);
               check_field("tx_byte", exp_w.tx_byte, rsp_tdata[7:0]);
               check_field("packet_kind", exp_w.packet_kind, rsp_tdata[10:8]);
               check_field("byte_index", exp_w.byte_index, rsp_tdata[15:11]);
               check_field("data_byte", exp_w.data_byte, rsp_tdata[23:16]);
               check_field("scan_word", exp_w.scan_word, rsp_tdata[63:24]);
               check_field("scan_count", exp_w.scan_count, rsp_tdata[95:64]);
               check_field("last", exp_w.last, rsp_tlast);
            end
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      rsp_entry_type none;
      int            useful;
      int            r;
      int            rk;
      int            len;
      int            total;
      int            abort_at;
      logic [7:0]    b;

      none       = '0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      rsp_tready = 1'b0;

      // Directed part.
      add_row(1'b1, 3'd0, 8'h00, 1,
              mk_rsp(KIND_IGNORED, 8'h00, 3'd0, 5'd0, 8'h00, '0, '0, 1'b1), none);
      add_row(1'b0, 3'd7, 8'h00, 1,
              mk_rsp(KIND_IGNORED, 8'h00, 3'd0, 5'd0, 8'h00, '0, '0, 1'b1), none);
      add_row(1'b0, REQ_NONE, 8'h00, 1,
              mk_rsp(KIND_IGNORED, 8'h00, 3'd0, 5'd0, 8'h00, '0, '0, 1'b1), none);
      add_row(1'b0, REQ_RESET, 8'h00, 2,
              mk_rsp(KIND_TX, SYNC_BYTE, REQ_RESET, 5'd0, 8'h00, '0, '0, 1'b0),
              mk_rsp(KIND_TX, 8'h40, REQ_RESET, 5'd0, 8'h00, '0, '0, 1'b1));
      // A byte after a reset request gets no response.
      add_row(1'b1, 3'd0, 8'hFF, 1,
              mk_rsp(KIND_IGNORED, 8'h00, 3'd0, 5'd0, 8'hFF, '0, '0, 1'b1), none);
      add_row(1'b0, REQ_SCAN, 8'h00, 2,
              mk_rsp(KIND_TX, SYNC_BYTE, REQ_SCAN, 5'd0, 8'h00, '0, '0, 1'b0),
              mk_rsp(KIND_TX, 8'h20, REQ_SCAN, 5'd0, 8'h00, '0, '0, 1'b1));
      add_row(1'b1, 3'd0, 8'h33, 1,
              mk_rsp(KIND_MISMATCH, 8'h00, REQ_SCAN, 5'd0, 8'h33, '0, '0, 1'b1), none);
      for (int i = 0; i < 6; i++) add_row(1'b1, 3'd0, DESC_SCAN[i*8 +: 8], 0, none, none);
      add_row(1'b1, 3'd0, 8'h81, 1,
              mk_rsp(KIND_DESC_DONE, 8'h00, REQ_SCAN, 5'd6, 8'h81, '0, '0, 1'b1), none);
      for (int i = 0; i < 5; i++) add_row(1'b1, 3'd0, (i % 2) ? 8'h00 : 8'hFF, 0, none, none);
      add_row(1'b0, REQ_FORCE_SCAN, 8'h00, 0, none, none);
      add_row(1'b0, REQ_INFO, 8'h00, 0, none, none);
      add_row(1'b0, REQ_HEALTH, 8'h00, 0, none, none);
      // Mismatch in the middle of the descriptor keeps the match position.
      add_row(1'b1, 3'd0, 8'hA5, 0, none, none);
      add_row(1'b1, 3'd0, 8'h00, 0, none, none);
      add_row(1'b1, 3'd0, 8'h5A, 0, none, none);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stim_table[i]) begin
         cur_typed_n = stim_table[i].n_typed;
         cur_t0      = stim_table[i].t0;
         cur_t1      = stim_table[i].t1;
         send_word(stim_table[i].act, stim_table[i].rk, stim_table[i].rb);
      end
      cur_typed_n = 0;
      drain_responses();

      // Random part: mostly well-formed sessions with random payload.
      useful = 0;
      while (useful < RANDOM_ITEMS) begin
         calm = (useful >= 200 && useful < 300);
         r = $urandom_range(99);
         if (r < 6) begin
            drain_responses();
         end else if (r < 80) begin
            rk = ($urandom_range(99) < 50) ? $urandom_range(0, 1) : $urandom_range(2, 3);
            send_word(1'b0, rk[2:0], 8'($urandom_range(0, 255)));
            useful++;
            for (int p = 0; p < 7; p++) begin
               if ($urandom_range(99) < 8) begin
                  send_word(1'b1, 3'd0, 8'($urandom_range(0, 255)));
                  useful++;
               end
               send_word(1'b1, 3'd0, desc_at(rk[2:0], p[2:0]));
               useful++;
            end
            len = payload_size(rk[2:0]);
            total = len * ((rk == REQ_INFO) ? $urandom_range(1, 2) : $urandom_range(1, 5));
            abort_at = ($urandom_range(99) < 15) ? $urandom_range(0, total - 1) : total;
            for (int j = 0; j < abort_at; j++) begin
               r = $urandom_range(99);
               if (r < 10) b = 8'h00;
               else if (r < 20) b = 8'hFF;
               else b = 8'($urandom_range(0, 255));
               send_word(1'b1, 3'($urandom_range(0, 7)), b);
               useful++;
            end
         end else if (r < 88) begin
            send_word(1'b0, REQ_RESET, 8'($urandom_range(0, 255)));
            useful++;
            repeat ($urandom_range(1, 4)) send_word(1'b1, 3'd0, 8'($urandom_range(0, 255)));
         end else if (r < 94) begin
            send_word(1'b0, 3'($urandom_range(REQ_NONE, 7)), 8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 5)) begin
               send_word(1'b1, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
               useful++;
            end
         end
      end

      calm = 1'b0;
      drain_responses();
      repeat (20) @(posedge clock);
      if (err_count == 0 && awaited_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
